### hdl/twiddle_param_tuner_macros.svh
// assertion macros for the twiddle parameter tuner checker
`ifndef TWIDDLE_PARAM_TUNER_MACROS_SVH
`define TWIDDLE_PARAM_TUNER_MACROS_SVH

// same-cycle implication, reset masked
`define TPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define TPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tpt_pkg.sv
// shared types and constants for the twiddle parameter tuner
`timescale 1ns / 1ps
`default_nettype none

package tpt_pkg;

  localparam int TUNED_PARAMS = 3;
  localparam int NUM_SLOTS    = 3;
  localparam int IDX_W        = 2;
  localparam int DATA_W       = 32;
  localparam int STEP_W       = 31;
  localparam int FACTOR_W     = 17;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = STEP_W + FACTOR_W;
  localparam int SUM_W        = DATA_W + 1;
  localparam int CFG_IDX_W    = 3;

  localparam logic [FACTOR_W-1:0] GROW_Q16   = FACTOR_W'(72090);
  localparam logic [FACTOR_W-1:0] SHRINK_Q16 = FACTOR_W'(58982);

  localparam logic [DATA_W-1:0] TOL_RESET  = DATA_W'(13107);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PARAM_0 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PARAM_1 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PARAM_2 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP_0  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP_1  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP_2  = CFG_IDX_W'(6);

  typedef enum logic [3:0] {
    PH_INIT,
    PH_CHECK_TOL,
    PH_NEXT,
    PH_INC,
    PH_CHECK_INC,
    PH_GROW_INC,
    PH_DEC,
    PH_CHECK_DEC,
    PH_SCALE_DEC,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic take_err;
    logic load_init;
    logic set_best;
    logic clr_index;
    logic inc_index;
    logic param_add;
    logic param_sub2;
    logic mul_en;
    logic mul_grow;
    logic write_step;
    logic emit;
    logic emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic tol_met;
    logic idx_end;
    logic improved;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/tpt_ctrl.sv
// phase sequencer and handshake control for the twiddle tuner
`timescale 1ns / 1ps
`default_nettype none

module tpt_ctrl import tpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  phase_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_INIT;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (busy_r) begin
      unique case (state_r)
        PH_INIT:      state_nxt = PH_CHECK_TOL;
        PH_CHECK_TOL: state_nxt = status.tol_met ? PH_DONE : PH_NEXT;
        PH_NEXT:      state_nxt = status.idx_end ? PH_CHECK_TOL : PH_INC;
        PH_INC:       state_nxt = out_free ? PH_CHECK_INC : PH_INC;
        PH_CHECK_INC: state_nxt = status.improved ? PH_GROW_INC : PH_DEC;
        PH_GROW_INC:  state_nxt = PH_NEXT;
        PH_DEC:       state_nxt = out_free ? PH_CHECK_DEC : PH_DEC;
        PH_CHECK_DEC: state_nxt = PH_SCALE_DEC;
        PH_SCALE_DEC: state_nxt = PH_NEXT;
        PH_DONE:      state_nxt = PH_DONE;
        default:      state_nxt = PH_INIT;
      endcase
    end
  end

  always_comb begin
    logic finish;
    finish        = 1'b0;
    cmd           = '0;
    cmd.take_err  = in_valid & ~busy_r;
    if (busy_r) begin
      unique case (state_r)
        PH_INIT: cmd.load_init = 1'b1;
        PH_CHECK_TOL: cmd.clr_index = ~status.tol_met;
        PH_INC: begin
          cmd.param_add = out_free;
          cmd.emit      = out_free;
          finish        = out_free;
        end
        PH_CHECK_INC: begin
          cmd.set_best = status.improved;
          cmd.mul_en   = status.improved;
          cmd.mul_grow = 1'b1;
        end
        PH_DEC: begin
          cmd.param_sub2 = out_free;
          cmd.emit       = out_free;
          finish         = out_free;
        end
        PH_CHECK_DEC: begin
          cmd.set_best  = status.improved;
          cmd.param_add = ~status.improved;
          cmd.mul_en    = 1'b1;
          cmd.mul_grow  = status.improved;
        end
        PH_GROW_INC, PH_SCALE_DEC: begin
          cmd.write_step = 1'b1;
          cmd.inc_index  = 1'b1;
        end
        PH_NEXT: ;
        PH_DONE: begin
          cmd.emit      = out_free;
          cmd.emit_done = 1'b1;
          finish        = out_free;
        end
        default: ;
      endcase
    end
    busy_nxt      = busy_r ? ~finish : cmd.take_err;
    out_valid_nxt = finish | (out_valid_r & out_stall);
  end

endmodule

`default_nettype wire

### hdl/tpt_datapath.sv
// parameter, step and error registers with their arithmetic for the twiddle tuner
`timescale 1ns / 1ps
`default_nettype none

module tpt_datapath import tpt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic [DATA_W-1:0]        in_error_value,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  output logic signed [DATA_W-1:0] out_param_out_0,
  output logic signed [DATA_W-1:0] out_param_out_1,
  output logic signed [DATA_W-1:0] out_param_out_2,
  output logic [DATA_W-1:0]        out_best_error_out,
  output logic                     out_tuning_done
);

  localparam logic [DATA_W-1:0] PARAM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] PARAM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] tol_r;
  logic [DATA_W-1:0] init_param_r [NUM_SLOTS];
  logic [STEP_W-1:0] init_step_r  [NUM_SLOTS];

  logic [DATA_W-1:0] param_r [NUM_SLOTS];
  logic [DATA_W-1:0] param_nxt [NUM_SLOTS];
  logic [STEP_W-1:0] step_r [NUM_SLOTS];
  logic [STEP_W-1:0] step_nxt [NUM_SLOTS];
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [DATA_W-1:0] err_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [PROD_W-1:0] prod_r;

  logic [DATA_W-1:0] out_param_r [NUM_SLOTS];
  logic [DATA_W-1:0] out_best_r;
  logic              out_done_r;

  logic [IDX_W-1:0]    sel_idx;
  logic [STEP_W-1:0]   cur_step;
  logic [DATA_W-1:0]   cur_param;
  logic [DATA_W+1:0]   step_ext;
  logic [DATA_W+1:0]   delta;
  logic [DATA_W+1:0]   param_sum;
  logic [DATA_W-1:0]   param_upd;
  logic [STEP_W-1:0]   scaled_step;
  logic [FACTOR_W-1:0] factor;
  logic [SUM_W-1:0]    step_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        init_param_r[k] <= '0;
        init_step_r[k]  <= STEP_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOLERANCE:    tol_r           <= cfg_wdata;
        CFG_INIT_PARAM_0: init_param_r[0] <= cfg_wdata;
        CFG_INIT_PARAM_1: init_param_r[1] <= cfg_wdata;
        CFG_INIT_PARAM_2: init_param_r[2] <= cfg_wdata;
        CFG_INIT_STEP_0:  init_step_r[0]  <= cfg_wdata[STEP_W-1:0];
        CFG_INIT_STEP_1:  init_step_r[1]  <= cfg_wdata[STEP_W-1:0];
        CFG_INIT_STEP_2:  init_step_r[2]  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_err) begin
      err_r <= in_error_value;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(cur_step) * PROD_W'(factor);
    end
  end

  assign sel_idx   = (idx_r < IDX_W'(TUNED_PARAMS)) ? idx_r : '0;
  assign cur_step  = step_r[sel_idx];
  assign cur_param = param_r[sel_idx];
  assign factor    = cmd.mul_grow ? GROW_Q16 : SHRINK_Q16;

  // exact add of +d or -2d, then clamp to the signed range
  assign step_ext  = (DATA_W+2)'(cur_step);
  assign delta     = cmd.param_add ? step_ext : -(step_ext << 1);
  assign param_sum = {{2{cur_param[DATA_W-1]}}, cur_param} + delta;

  always_comb begin
    if (param_sum[DATA_W+1:DATA_W-1] == '0 || param_sum[DATA_W+1:DATA_W-1] == '1) begin
      param_upd = param_sum[DATA_W-1:0];
    end else if (param_sum[DATA_W+1]) begin
      param_upd = PARAM_MIN;
    end else begin
      param_upd = PARAM_MAX;
    end
  end

  // q1.16 scale, truncated, clamped to the step range
  assign scaled_step = prod_r[PROD_W-1] ? '1 : prod_r[PROD_W-2:FRAC_W];

  always_comb begin
    step_total = '0;
    for (int k = 0; k < TUNED_PARAMS; k++) begin
      step_total = step_total + SUM_W'(step_r[k]);
    end
  end

  assign status.tol_met  = step_total <= SUM_W'(tol_r);
  assign status.idx_end  = idx_r >= IDX_W'(TUNED_PARAMS);
  assign status.improved = err_r < best_r;

  always_comb begin
    param_nxt = param_r;
    step_nxt  = step_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    if (cmd.load_init) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        param_nxt[k] = init_param_r[k];
        step_nxt[k]  = init_step_r[k];
      end
      best_nxt = err_r;
    end
    if (cmd.set_best) begin
      best_nxt = err_r;
    end
    if (cmd.param_add || cmd.param_sub2) begin
      param_nxt[sel_idx] = param_upd;
    end
    if (cmd.write_step) begin
      step_nxt[sel_idx] = scaled_step;
    end
    if (cmd.clr_index) begin
      idx_nxt = '0;
    end else if (cmd.inc_index) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        param_r[k] <= '0;
        step_r[k]  <= STEP_RESET;
      end
      best_r     <= '0;
      idx_r      <= '0;
      out_done_r <= 1'b0;
    end else begin
      param_r <= param_nxt;
      step_r  <= step_nxt;
      best_r  <= best_nxt;
      idx_r   <= idx_nxt;
      if (cmd.emit) begin
        out_done_r <= cmd.emit_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_param_r <= param_nxt;
      out_best_r  <= best_r;
    end
  end

  assign out_param_out_0    = out_param_r[0];
  assign out_param_out_1    = out_param_r[1];
  assign out_param_out_2    = out_param_r[2];
  assign out_best_error_out = out_best_r;
  assign out_tuning_done    = out_done_r;

endmodule

`default_nettype wire

### hdl/twiddle_param_tuner.sv
// top level of the twiddle coordinate-descent tuner
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_error_value
//   out      output     out_valid / out_stall param_out_0..2, best_error_out, tuning_done
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// one error item gives one result after a walk through the phases, the
// longest walk being a step update through the registered multiplier
// followed by a tolerance recheck
// rst_n is synchronous; after reset the first item reloads params and steps
// in_stall is high from an input transfer until its result is loaded
// a result waiting on out_stall holds the walk at the measuring phase
`timescale 1ns / 1ps
`default_nettype none

module twiddle_param_tuner import tpt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DATA_W-1:0]        in_error_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_param_out_0,
  output logic signed [DATA_W-1:0] out_param_out_1,
  output logic signed [DATA_W-1:0] out_param_out_2,
  output logic [DATA_W-1:0]        out_best_error_out,
  output logic                     out_tuning_done
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tpt_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_error_value     (in_error_value),
    .cmd                (cmd),
    .status             (status),
    .out_param_out_0    (out_param_out_0),
    .out_param_out_1    (out_param_out_1),
    .out_param_out_2    (out_param_out_2),
    .out_best_error_out (out_best_error_out),
    .out_tuning_done    (out_tuning_done)
  );

endmodule

`default_nettype wire

### hdl/tpt_checker.sv
// port-level assertions for the twiddle tuner and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "twiddle_param_tuner_macros.svh"

module tpt_checker import tpt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_param_out_0,
  input logic [DATA_W-1:0] out_param_out_1,
  input logic [DATA_W-1:0] out_param_out_2,
  input logic [DATA_W-1:0] out_best_error_out,
  input logic              out_tuning_done
);

  // stalled result stays offered
  `TPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

  // stalled result payload holds
  `TPT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_param_out_0) && $stable(out_param_out_1) && $stable(out_param_out_2) && $stable(out_best_error_out), "stalled result changed")

  // one item in flight at a time
  `TPT_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "second item taken while busy")

  // once stopped, tuning stays stopped and the best error is frozen
  `TPT_ASSERT_NEXT(a_done_sticky, out_tuning_done, out_tuning_done && $stable(out_best_error_out) && $stable(out_param_out_0), "tuning restarted after done")

endmodule

bind twiddle_param_tuner tpt_checker u_tpt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_param_out_0    (out_param_out_0),
  .out_param_out_1    (out_param_out_1),
  .out_param_out_2    (out_param_out_2),
  .out_best_error_out (out_best_error_out),
  .out_tuning_done    (out_tuning_done)
);

`default_nettype wire

### test/twiddle_param_tuner_test.sv
// self-checking testbench for the twiddle parameter tuner
`timescale 1ns / 1ps

module twiddle_param_tuner_test;
  import tpt_pkg::*;

  localparam longint SAT_HI = 64'sh7FFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000;
  localparam int LONG_HOLD = 300;
  localparam logic [DATA_W-1:0] OPENING [14] = '{
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
    32'h0001_0000, 32'h8000_0000, 32'h0000_FFFF, 32'h7FFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'h0000_FFFE,
    32'h0000_8001, 32'hFFFF_0000
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] p0;
    logic signed [DATA_W-1:0] p1;
    logic signed [DATA_W-1:0] p2;
    logic [DATA_W-1:0]        best;
    logic                     done;
  } tuning_result_t;

  class tuning_tracker;
    int unsigned mismatches;
    phase_t ph;
    logic [DATA_W-1:0] best;
    logic signed [DATA_W-1:0] prm [NUM_SLOTS];
    logic [STEP_W-1:0] stp [NUM_SLOTS];
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] tol;
    logic [DATA_W-1:0] start_prm [NUM_SLOTS];
    logic [STEP_W-1:0] start_stp [NUM_SLOTS];
    tuning_result_t pending_tunings [$];

    function new();
      mismatches = 0;
      ph = PH_INIT;
      best = '0;
      idx = '0;
      tol = TOL_RESET;
      foreach (start_prm[k]) begin
        start_prm[k] = '0;
        start_stp[k] = STEP_RESET;
      end
      reload();
    endfunction

    function void reload();
      foreach (prm[k]) begin
        prm[k] = start_prm[k];
        stp[k] = start_stp[k];
      end
    endfunction

    function logic signed [DATA_W-1:0] sat(longint v);
      if (v > SAT_HI) return SAT_HI[DATA_W-1:0];
      if (v < SAT_LO) return SAT_LO[DATA_W-1:0];
      return v[DATA_W-1:0];
    endfunction

    function logic [STEP_W-1:0] scale(logic [STEP_W-1:0] s, logic [FACTOR_W-1:0] f);
      logic [PROD_W-1:0] p;
      p = (PROD_W'(s) * PROD_W'(f)) >> FRAC_W;
      if (p > PROD_W'({STEP_W{1'b1}})) return '1;
      return p[STEP_W-1:0];
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] sel, logic [DATA_W-1:0] val);
      case (sel)
        CFG_TOLERANCE: tol = val;
        CFG_INIT_PARAM_0: start_prm[0] = val;
        CFG_INIT_PARAM_1: start_prm[1] = val;
        CFG_INIT_PARAM_2: start_prm[2] = val;
        CFG_INIT_STEP_0: start_stp[0] = val[STEP_W-1:0];
        CFG_INIT_STEP_1: start_stp[1] = val[STEP_W-1:0];
        CFG_INIT_STEP_2: start_stp[2] = val[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // walk the phases until a new measurement is needed
    function void take_error(logic [DATA_W-1:0] err);
      logic waiting;
      int unsigned i;
      logic [SUM_W:0] total;
      tuning_result_t r;
      waiting = 1'b0;
      for (int g = 0; g < 16 && !waiting; g++) begin
        i = idx;
        case (ph)
          PH_INIT: begin
            reload();
            best = err;
            ph = PH_CHECK_TOL;
          end
          PH_CHECK_TOL: begin
            total = '0;
            for (int k = 0; k < TUNED_PARAMS; k++) total += stp[k];
            if (total > tol) begin
              idx = '0;
              ph = PH_NEXT;
            end else begin
              ph = PH_DONE;
            end
          end
          PH_NEXT: ph = (i >= TUNED_PARAMS) ? PH_CHECK_TOL : PH_INC;
          PH_INC: begin
            prm[i] = sat(longint'(prm[i]) + longint'(stp[i]));
            ph = PH_CHECK_INC;
            waiting = 1'b1;
          end
          PH_CHECK_INC: begin
            if (err < best) begin
              best = err;
              stp[i] = scale(stp[i], GROW_Q16);
              idx = IDX_W'(i + 1);
              ph = PH_NEXT;
            end else begin
              ph = PH_DEC;
            end
          end
          PH_DEC: begin
            prm[i] = sat(longint'(prm[i]) - 2 * longint'(stp[i]));
            ph = PH_CHECK_DEC;
            waiting = 1'b1;
          end
          PH_CHECK_DEC: begin
            if (err < best) begin
              best = err;
              stp[i] = scale(stp[i], GROW_Q16);
            end else begin
              prm[i] = sat(longint'(prm[i]) + longint'(stp[i]));
              stp[i] = scale(stp[i], SHRINK_Q16);
            end
            idx = IDX_W'(i + 1);
            ph = PH_NEXT;
          end
          default: waiting = 1'b1;
        endcase
      end
      r.p0 = prm[0];
      r.p1 = prm[1];
      r.p2 = prm[2];
      r.best = best;
      r.done = (ph == PH_DONE);
      pending_tunings.push_back(r);
    endfunction

    function bit at_last_dec();
      return ph == PH_CHECK_DEC && idx == IDX_W'(TUNED_PARAMS - 1);
    endfunction

    // step sum seen by the next tolerance check when the last step shrinks
    function logic [SUM_W:0] sum_after_shrink();
      logic [SUM_W:0] total;
      total = '0;
      for (int k = 0; k < TUNED_PARAMS; k++)
        total += (k == TUNED_PARAMS - 1) ? scale(stp[k], SHRINK_Q16) : stp[k];
      return total;
    endfunction

    function int unsigned pending_count();
      return pending_tunings.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic signed [DATA_W-1:0] p0, logic signed [DATA_W-1:0] p1,
                      logic signed [DATA_W-1:0] p2, logic [DATA_W-1:0] b, logic d);
      tuning_result_t want;
      if (pending_tunings.size() == 0) begin
        report("result transfer with nothing pending");
        return;
      end
      want = pending_tunings.pop_front();
      if (p0 !== want.p0) report($sformatf("param_out_0 got %h expected %h", p0, want.p0));
      if (p1 !== want.p1) report($sformatf("param_out_1 got %h expected %h", p1, want.p1));
      if (p2 !== want.p2) report($sformatf("param_out_2 got %h expected %h", p2, want.p2));
      if (b !== want.best) report($sformatf("best_error_out got %h expected %h", b, want.best));
      if (d !== want.done) report($sformatf("tuning_done got %b expected %b", d, want.done));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [DATA_W-1:0] in_error_value;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_param_out_0;
  logic signed [DATA_W-1:0] out_param_out_1;
  logic signed [DATA_W-1:0] out_param_out_2;
  logic [DATA_W-1:0] out_best_error_out;
  logic out_tuning_done;

  bit calm;
  bit hold_out;
  tuning_tracker sb = new();

  twiddle_param_tuner dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_error_value     (in_error_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_param_out_0    (out_param_out_0),
    .out_param_out_1    (out_param_out_1),
    .out_param_out_2    (out_param_out_2),
    .out_best_error_out (out_best_error_out),
    .out_tuning_done    (out_tuning_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function int unsigned pick_wait();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // 30% small improvements on the best error, 6% ties, rest noise
  function logic [DATA_W-1:0] next_error();
    logic [DATA_W-1:0] b;
    int unsigned r;
    b = sb.best;
    r = $urandom_range(0, 99);
    if (r < 30 && b != 0) return b - $urandom_range(1, (b < 4096) ? b : 4096);
    if (r < 36) return b;
    if (r < 40) return '1;
    return $urandom();
  endfunction

  // entered and left at a falling edge
  task program_reg(logic [CFG_IDX_W-1:0] sel, logic [DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = sel;
    cfg_wdata = val;
    sb.set_register(sel, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task send_error(logic [DATA_W-1:0] e);
    int unsigned w;
    w = pick_wait();
    if (w != 0) begin
      in_valid = 1'b0;
      repeat (w) @(negedge clk);
    end
    in_valid = 1'b1;
    in_error_value = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_error(e);
    @(negedge clk);
  endtask

  task run_random(int n);
    repeat (n) send_error(next_error());
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task walk_to_last_dec();
    while (!sb.at_last_dec() && sb.ph != PH_DONE) send_error('1);
  endtask

  initial begin
    int unsigned w;
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_out && !held) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end else begin
        w = pick_wait();
        if (w != 0) begin
          out_stall = 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_param_out_0, out_param_out_1, out_param_out_2,
                      out_best_error_out, out_tuning_done);
  end

  initial begin
    logic [SUM_W:0] total;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_error_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TOLERANCE;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_out = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // starting point at the range limits, only the last write of a register counts
    program_reg(CFG_INIT_PARAM_2, $urandom());
    program_reg(CFG_TOLERANCE, '0);
    program_reg(CFG_INIT_PARAM_0, 32'h7FFF_FFFF);
    program_reg(CFG_INIT_PARAM_1, 32'h8000_0000);
    program_reg(CFG_INIT_PARAM_2, $urandom());
    program_reg(CFG_INIT_STEP_0, 32'hFFFF_FFFF);
    program_reg(CFG_INIT_STEP_1, 32'h7FFF_FFFF);
    program_reg(CFG_INIT_STEP_2, DATA_W'($urandom_range(1, 1 << 20)));
    foreach (OPENING[j]) send_error(OPENING[j]);

    run_random(450);

    // start values written after the first item must be ignored
    wait_drained();
    program_reg(CFG_TOLERANCE, DATA_W'($urandom_range(1, 65535)));
    for (int j = 0; j < 6; j++)
      program_reg(CFG_IDX_W'(CFG_INIT_PARAM_0 + j), $urandom());
    hold_out = 1'b1;
    run_random(150);
    calm = 1'b1;
    run_random(100);
    calm = 1'b0;
    run_random(200);

    wait_drained();
    program_reg(CFG_TOLERANCE, DATA_W'($urandom_range(65536, 1 << 24)));
    run_random(400);

    // tolerance just below, then exactly at the step sum
    send_error('0);
    walk_to_last_dec();
    wait_drained();
    total = sb.sum_after_shrink();
    program_reg(CFG_TOLERANCE, (total == 0) ? '0 :
                (total > {DATA_W{1'b1}}) ? '1 : DATA_W'(total - 1));
    send_error('1);
    wait_drained();
    program_reg(CFG_TOLERANCE, '0);
    walk_to_last_dec();
    wait_drained();
    total = sb.sum_after_shrink();
    program_reg(CFG_TOLERANCE, (total > {DATA_W{1'b1}}) ? '1 : DATA_W'(total));
    send_error('1);
    run_random(12);

    wait_drained();
    program_reg(CFG_TOLERANCE, '1);
    program_reg(CFG_INIT_STEP_1, '0);
    run_random(6);

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/tpt_pkg.sv
hdl/tpt_ctrl.sv
hdl/tpt_datapath.sv
hdl/twiddle_param_tuner.sv
hdl/tpt_checker.sv
test/twiddle_param_tuner_test.sv
